// ===== rtl/core/cfu_pkg.sv =====
// shared types and constants of the status flag unit
package cfu_pkg;

	typedef logic [1:0] op_t;
	typedef logic [7:0] byte_t;

	localparam op_t OP_ALL      = 2'd0;
	localparam op_t OP_NO_CARRY = 2'd1;
	localparam op_t OP_CARRY    = 2'd2;
	localparam op_t OP_NONE     = 2'd3;

	localparam int unsigned FLAG_CARRY  = 0;
	localparam int unsigned FLAG_ONE    = 1;
	localparam int unsigned FLAG_PARITY = 2;
	localparam int unsigned FLAG_GAP3   = 3;
	localparam int unsigned FLAG_AUX    = 4;
	localparam int unsigned FLAG_GAP5   = 5;
	localparam int unsigned FLAG_ZERO   = 6;
	localparam int unsigned FLAG_SIGN   = 7;

	localparam byte_t FLAGS_RESET = 8'h02;

	typedef struct packed {
		op_t   op;
		logic  subtract;
		byte_t operand_a;
		byte_t operand_b;
	} req_t;

endpackage

// ===== rtl/core/cfu_req_if.sv =====
// request channel of the status flag unit
interface cfu_req_if;
	import cfu_pkg::*;

	logic  valid;
	logic  ready;
	op_t   op;
	logic  subtract;
	byte_t operand_a;
	byte_t operand_b;

	modport source (output valid, output op, output subtract, output operand_a,
		output operand_b, input ready);
	modport sink (input valid, input op, input subtract, input operand_a,
		input operand_b, output ready);
endinterface

// ===== rtl/core/cfu_rsp_if.sv =====
// response channel of the status flag unit
interface cfu_rsp_if;
	import cfu_pkg::*;

	logic  valid;
	logic  ready;
	byte_t flag_byte;

	modport source (output valid, output flag_byte, input ready);
	modport sink (input valid, input flag_byte, output ready);
endinterface

// ===== rtl/core/cpu8_status_flag_unit_core.sv =====
// top level of the status flag unit: request register, flag update, response register
// Keeps an 8080-style flag register (sign, zero, aux carry, parity, carry) and updates
// it from one add or subtract request per cycle, while responses are taken, under the
// request's flag rule; each request returns the new flag byte. A request is registered
// on acceptance and the flags are updated as it moves into the response register; the
// sustained rate is one request per cycle while responses are taken, and one more
// request is still taken while a finished response waits to be taken.
module cpu8_status_flag_unit_core (
	input logic      clk,
	input logic      arst_n,
	cfu_req_if.sink  req,
	cfu_rsp_if.source rsp
);
	import cfu_pkg::*;

	logic  valid_s1;
	req_t  req_s1;
	logic  rsp_valid_q;
	byte_t rsp_flags_q;
	byte_t flags_q;
	byte_t flags_nxt;
	logic  advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= '{op: req.op, subtract: req.subtract,
				operand_a: req.operand_a, operand_b: req.operand_b};
		end
	end

	cfu_flag_logic u_flag_logic (
		.req       (req_s1),
		.flags_cur (flags_q),
		.flags_nxt (flags_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= FLAGS_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flags_q <= flags_nxt;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_flags_q <= flags_nxt;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.flag_byte = rsp_flags_q;

`ifndef SYNTHESIS
	a_fixed_bits: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q[FLAG_ONE] && !flags_q[FLAG_GAP3] && !flags_q[FLAG_GAP5])
		else $error("fixed flag bits corrupted");

	a_rsp_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp.valid && (rsp.flag_byte == flags_q))
		else $error("response differs from stored flags");

	a_none_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_s1.op == OP_NONE) |=> $stable(flags_q))
		else $error("rule none changed flags");

	a_carry_only: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_s1.op == OP_CARRY) |=> $stable(flags_q[7:1]))
		else $error("carry rule changed other flags");

	a_idle_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(flags_q))
		else $error("flags changed without a request");
`endif
endmodule

// ===== rtl/core/cfu_flag_logic.sv =====
// next flag value from one arithmetic request and the current flags
module cfu_flag_logic (
	input  cfu_pkg::req_t  req,
	input  cfu_pkg::byte_t flags_cur,
	output cfu_pkg::byte_t flags_nxt
);
	import cfu_pkg::*;

	logic [8:0] res;
	byte_t      lo;
	byte_t      nb;
	logic       upd_carry;
	logic       upd_rest;
	logic       carry;
	logic [4:0] nib_add;
	logic [4:0] nib_sub;
	logic       aux;
	byte_t      f;

	always_comb begin
		if (req.subtract) begin
			res = {1'b0, req.operand_a} - {1'b0, req.operand_b};
		end else begin
			res = {1'b0, req.operand_a} + {1'b0, req.operand_b};
		end
		lo = res[7:0];
		nb = ~req.operand_b;

		upd_carry = (req.op == OP_ALL) || (req.op == OP_CARRY);
		upd_rest  = (req.op == OP_ALL) || (req.op == OP_NO_CARRY);

		carry = upd_carry ? res[8] : flags_cur[FLAG_CARRY];

		// nibble carry out, with borrow-in taken from the carry as updated
		nib_add = {1'b0, req.operand_a[3:0]} + {1'b0, req.operand_b[3:0]};
		nib_sub = {1'b0, req.operand_a[3:0]} + {1'b0, nb[3:0]} + {4'd0, ~carry};
		aux = req.subtract ? nib_sub[4] : nib_add[4];

		f = flags_cur;
		f[FLAG_CARRY] = carry;
		if (upd_rest) begin
			f[FLAG_ZERO]   = (lo == 8'd0);
			f[FLAG_SIGN]   = lo[7];
			f[FLAG_PARITY] = ~^lo;
			f[FLAG_AUX]    = aux;
		end
		f[FLAG_ONE]  = 1'b1;
		f[FLAG_GAP3] = 1'b0;
		f[FLAG_GAP5] = 1'b0;
		flags_nxt = f;
	end
endmodule

// ===== tb/tb.sv =====
// testbench of the status flag unit: directed and random requests against a flag predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfu_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;

	logic clk;
	logic arst_n;

	cfu_req_if req_ch ();
	cfu_rsp_if rsp_ch ();

	cpu8_status_flag_unit_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	byte_t flags_model;
	byte_t expected_flags[$];
	int    err_count;
	int    idle_cycles;
	int    hold_cnt;
	bit    idle_on;

	always #4 clk = ~clk;

	function automatic int pick_len(int short_pct);
		if ($urandom_range(0, 99) < short_pct) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_gap();
		if (!idle_on || $urandom_range(0, 99) < 55) begin
			return 0;
		end
		return pick_len(85);
	endfunction

	function automatic byte_t edge_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h0F;
			3: return 8'h10;
			4: return 8'h7F;
			5: return 8'h80;
			6: return 8'h01;
			default: return byte_t'($urandom);
		endcase
	endfunction

	function automatic byte_t update_flags(byte_t cur, req_t r);
		logic [15:0] wide;
		logic [9:0]  nib_sum;
		byte_t       lo;
		byte_t       nb;
		byte_t       f;
		f = cur;
		if (r.subtract) begin
			wide = {8'h00, r.operand_a} - {8'h00, r.operand_b};
		end else begin
			wide = {8'h00, r.operand_a} + {8'h00, r.operand_b};
		end
		lo = wide[7:0];
		if (r.op == OP_ALL || r.op == OP_CARRY) begin
			f[FLAG_CARRY] = wide[8];
		end
		if (r.op == OP_ALL || r.op == OP_NO_CARRY) begin
			f[FLAG_ZERO]   = (lo == 8'h00);
			f[FLAG_SIGN]   = lo[7];
			f[FLAG_PARITY] = ~^lo;
			if (!r.subtract) begin
				f[FLAG_AUX] = ({1'b0, r.operand_a[3:0]} + {1'b0, r.operand_b[3:0]}) > 5'h0F;
			end else begin
				// borrow-in is the carry as it stands now
				nb = ~r.operand_b;
				nib_sum = {2'b00, r.operand_a} + {2'b00, nb} + {9'd0, ~f[FLAG_CARRY]};
				f[FLAG_AUX] = nib_sum[4] ^ r.operand_a[4] ^ nb[4];
			end
		end
		f[FLAG_ONE]  = 1'b1;
		f[FLAG_GAP3] = 1'b0;
		f[FLAG_GAP5] = 1'b0;
		return f;
	endfunction

	task automatic report_mismatch(string what, byte_t got, byte_t want);
		$display("[%0t] %s: got %02h want %02h", $time, what, got, want);
		err_count++;
	endtask

	task automatic send_req(op_t op, logic sub, byte_t a, byte_t b);
		req_t r;
		int   gap;
		r.op        = op;
		r.subtract  = sub;
		r.operand_a = a;
		r.operand_b = b;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.op        <= op;
		req_ch.subtract  <= sub;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		flags_model = update_flags(flags_model, r);
		expected_flags.push_back(flags_model);
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_flags.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		idle_on = 1'b0;
		send_req(OP_ALL, 1'b0, 8'h00, 8'h00);
		send_req(OP_ALL, 1'b0, 8'hFF, 8'h01);
		send_req(OP_ALL, 1'b0, 8'h0F, 8'h01);
		send_req(OP_ALL, 1'b0, 8'h7F, 8'h01);
		send_req(OP_ALL, 1'b1, 8'h00, 8'h01);
		send_req(OP_ALL, 1'b1, 8'h10, 8'h01);
		send_req(OP_ALL, 1'b1, 8'hFF, 8'hFF);
		send_req(OP_NO_CARRY, 1'b0, 8'hFF, 8'hFF);
		send_req(OP_NO_CARRY, 1'b1, 8'h00, 8'hFF);
		send_req(OP_CARRY, 1'b0, 8'h80, 8'h80);
		send_req(OP_CARRY, 1'b1, 8'h00, 8'h00);
		send_req(OP_NO_CARRY, 1'b1, 8'h20, 8'h01);
		send_req(OP_NONE, 1'b0, 8'hFF, 8'hFF);
		send_req(OP_NONE, 1'b1, 8'h00, 8'h01);
		send_req(OP_ALL, 1'b0, 8'h55, 8'hAA);
		send_req(OP_ALL, 1'b1, 8'h55, 8'hAA);
		send_req(OP_CARRY, 1'b1, 8'h00, 8'h01);
		send_req(OP_NO_CARRY, 1'b1, 8'h10, 8'h00);
		send_req(OP_NONE, 1'b0, 8'h00, 8'h00);
		send_req(OP_ALL, 1'b0, 8'h01, 8'h02);
		wait_for_results();
	endtask

	task automatic test_random_ops();
		idle_on = 1'b1;
		repeat (600) begin
			send_req(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				byte_t'($urandom), byte_t'($urandom));
		end
	endtask

	task automatic test_operand_edges();
		idle_on = 1'b1;
		repeat (300) begin
			send_req(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				edge_byte(), edge_byte());
		end
		wait_for_results();
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (300) begin
			send_req(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				byte_t'($urandom), byte_t'($urandom));
		end
	endtask

	task automatic test_carry_then_sub();
		idle_on = 1'b1;
		repeat (100) begin
			send_req(OP_CARRY, 1'($urandom_range(0, 1)), edge_byte(), edge_byte());
			send_req(OP_NO_CARRY, 1'b1, byte_t'($urandom), edge_byte());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_flags.size() == 0) begin
				report_mismatch("unexpected result", rsp_ch.flag_byte, 8'h00);
			end else if (rsp_ch.flag_byte !== expected_flags[0]) begin
				report_mismatch("flag_byte mismatch", rsp_ch.flag_byte, expected_flags.pop_front());
			end else begin
				void'(expected_flags.pop_front());
			end
		end
		if (!idle_on) begin
			rsp_ch.ready <= 1'b1;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
		end else if (rsp_ch.ready) begin
			rsp_ch.ready <= 1'b0;
			hold_cnt = pick_len(85) - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			hold_cnt = $urandom_range(0, 12);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.op        = OP_ALL;
		req_ch.subtract  = 1'b0;
		req_ch.operand_a = 8'h00;
		req_ch.operand_b = 8'h00;
		rsp_ch.ready     = 1'b0;
		flags_model      = FLAGS_RESET;
		err_count        = 0;
		idle_cycles      = 0;
		hold_cnt         = 0;
		idle_on          = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_ops();
		test_operand_edges();
		test_back_to_back();
		test_carry_then_sub();

		wait_for_results();
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
